// ===== rtl/wella_pkg.sv =====
// Shared types and constants for the WELL1024a generator.
package wella_pkg;

	localparam int POOL_WORDS = 32;
	localparam int MIX_STEPS  = 1000;
	localparam int CNT_W      = 12;

	localparam logic [1:0] FUNC_DRAW32 = 2'd0;
	localparam logic [1:0] FUNC_DRAW64 = 2'd1;
	localparam logic [1:0] FUNC_RESEED = 2'd2;

	localparam logic [31:0] DEFAULT_WORDS [POOL_WORDS] = '{
		32'hf8c53aa7, 32'h16a4b97b, 32'h13ed4568, 32'h120e6496,
		32'h77bb4a8a, 32'heb39eae5, 32'h46555774, 32'h76d53591,
		32'h64f9b515, 32'hc5185564, 32'h76b545d0, 32'hd02bebe1,
		32'hc73982f9, 32'h5cc173a7, 32'hb7002b87, 32'h44d93488,
		32'he42e0343, 32'h19525a6c, 32'h38005946, 32'h3a92c714,
		32'h713da8b0, 32'had0d7988, 32'h0788d23a, 32'hd756c34c,
		32'h8d38a159, 32'h47c83127, 32'h65c0e1b3, 32'h141c0dd6,
		32'hef0fea11, 32'h4248804d, 32'h19dd12ef, 32'he3c9b5da
	};

	// sequencer to pool control
	typedef struct packed {
		logic load;
		logic step;
	} pool_ctl_t;

endpackage

// ===== rtl/wella_cmd_if.sv =====
// Request channel: function select and seed.
interface wella_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [63:0] seed;

	modport source(output valid, func, seed, input ready);
	modport sink(input valid, func, seed, output ready);
endinterface

// ===== rtl/wella_rnd_if.sv =====
// Result channel: random value.
interface wella_rnd_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;

	modport source(output valid, value, input ready);
	modport sink(input valid, value, output ready);
endinterface

// ===== rtl/wella_pool.sv =====
// Rotating 32-word pool with the single-step WELL1024a recurrence.
module wella_pool (
	input  logic                clk,
	input  logic                arst_n,
	input  wella_pkg::pool_ctl_t ctl,
	input  logic [63:0]         seed,
	output logic [31:0]         word
);

	// r_q[i] holds pool[(position + i) mod 32], so every tap is fixed
	logic [31:0] r_q [wella_pkg::POOL_WORDS];
	logic [31:0] b, c, new0, new1;

	always_comb begin
		b    = r_q[0] ^ r_q[3] ^ (r_q[3] >> 8);
		c    = r_q[24] ^ (r_q[24] << 19) ^ r_q[10] ^ (r_q[10] << 14);
		new0 = b ^ c;
		new1 = r_q[31] ^ (r_q[31] << 11) ^ b ^ (b << 7) ^ c ^ (c << 13);
	end

	assign word = new1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wella_pkg::POOL_WORDS; i++)
				r_q[i] <= wella_pkg::DEFAULT_WORDS[i];
		end else if (ctl.load) begin
			for (int i = 2; i < wella_pkg::POOL_WORDS; i++)
				r_q[i] <= wella_pkg::DEFAULT_WORDS[i];
			r_q[0] <= seed[31:0];
			r_q[1] <= seed[63:32];
		end else if (ctl.step) begin
			// position moves back by one: whole window rotates up
			for (int i = 2; i < wella_pkg::POOL_WORDS; i++)
				r_q[i] <= r_q[i-1];
			r_q[1] <= new0;
			r_q[0] <= new1;
		end
	end

endmodule

// ===== rtl/well1024a_random_generator.sv =====
// WELL1024a random generator: request, pool, output register.
//
// Requests arrive on cmd (valid/ready) carrying func and seed; results leave
// on rnd (valid/ready) carrying a 64-bit value.
//   draw32: one generator step; value = {32'b0, word}. No new request is
//           taken while the step runs.
//   draw64: two steps; value = {first word, second word}. No new request
//           is taken until both steps are done.
//   reseed: loads the default pool with the seed in words 0 and 1 when the
//           request is taken, then runs 1000 mixing steps; no result.
//           The block is busy until the mixing steps are done.
//   func 3: taken and ignored.
// The single step unit does one recurrence step per cycle in ST_RUN.
// A new request is taken only when the sequencer is idle and the output
// register is empty or being emptied.
// A result waits in the output register while rnd.ready is low.
// After arst_n the pool holds the default seed words at position 0 and no
// result is pending.
module well1024a_random_generator (
	input  logic         clk,
	input  logic         arst_n,
	wella_cmd_if.sink    cmd,
	wella_rnd_if.source  rnd
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                      state_q;
	logic [wella_pkg::CNT_W-1:0] cnt_q;
	logic                        draw_q;
	logic                        wide_q;
	logic [31:0]                 hi_q;
	logic                        out_valid_q;
	logic [63:0]                 out_value_q;

	wella_pkg::pool_ctl_t        ctl;
	logic [31:0]                 word;
	logic                        accept;

	assign cmd.ready = (state_q == ST_IDLE) && (!out_valid_q || rnd.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign rnd.valid = out_valid_q;
	assign rnd.value = out_value_q;

	assign ctl.load = accept && (cmd.func == wella_pkg::FUNC_RESEED);
	assign ctl.step = (state_q == ST_RUN);

	wella_pool u_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.seed   (cmd.seed),
		.word   (word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			draw_q      <= 1'b0;
			wide_q      <= 1'b0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rnd.ready)
						out_valid_q <= 1'b0;
					if (accept) begin
						case (cmd.func)
							wella_pkg::FUNC_DRAW32: begin
								state_q <= ST_RUN;
								cnt_q   <= wella_pkg::CNT_W'(1);
								draw_q  <= 1'b1;
								wide_q  <= 1'b0;
							end
							wella_pkg::FUNC_DRAW64: begin
								state_q <= ST_RUN;
								cnt_q   <= wella_pkg::CNT_W'(2);
								draw_q  <= 1'b1;
								wide_q  <= 1'b1;
							end
							wella_pkg::FUNC_RESEED: begin
								if (wella_pkg::MIX_STEPS != 0)
									state_q <= ST_RUN;
								cnt_q  <= wella_pkg::CNT_W'(wella_pkg::MIX_STEPS);
								draw_q <= 1'b0;
								wide_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					// output register is always empty while running
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == wella_pkg::CNT_W'(2))
						hi_q <= word;
					if (cnt_q == wella_pkg::CNT_W'(1)) begin
						state_q <= ST_IDLE;
						if (draw_q) begin
							out_valid_q <= 1'b1;
							out_value_q <= wide_q ? {hi_q, word} : {32'h0, word};
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_well1024a_random_generator.sv =====
// Self-checking testbench for the WELL1024a generator: directed table, then random requests.
`timescale 1ns / 100ps

module tb_well1024a_random_generator;

	localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
	localparam int          RANDOM_ITEMS   = 1900;
	localparam int          SEGMENT_ITEMS  = 100;
	localparam int          RX_HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES    = wella_pkg::MIX_STEPS + 100;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int          N_DIRECTED     = 21;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] seed;
		logic        quiet;   // row gives no result
	} request_row_t;

	localparam request_row_t DIRECTED [N_DIRECTED] = '{
		'{wella_pkg::FUNC_DRAW32, 64'h0000000000000000, 1'b0},
		'{wella_pkg::FUNC_DRAW32, 64'hffffffffffffffff, 1'b0},
		'{wella_pkg::FUNC_DRAW64, 64'h0000000000000000, 1'b0},
		'{FUNC_UNUSED,            64'hffffffffffffffff, 1'b1},
		'{wella_pkg::FUNC_DRAW64, 64'hffffffffffffffff, 1'b0},
		'{wella_pkg::FUNC_RESEED, 64'h0000000000000000, 1'b1},
		'{wella_pkg::FUNC_DRAW32, 64'h0000000000000000, 1'b0},
		'{wella_pkg::FUNC_DRAW64, 64'h0000000000000000, 1'b0},
		'{wella_pkg::FUNC_RESEED, 64'hffffffffffffffff, 1'b1},
		'{wella_pkg::FUNC_DRAW64, 64'h0000000000000000, 1'b0},
		'{wella_pkg::FUNC_DRAW32, 64'haaaaaaaaaaaaaaaa, 1'b0},
		'{wella_pkg::FUNC_RESEED, 64'h00000000ffffffff, 1'b1},
		'{wella_pkg::FUNC_DRAW64, 64'h0000000000000000, 1'b0},
		'{wella_pkg::FUNC_RESEED, 64'hffffffff00000000, 1'b1},
		'{wella_pkg::FUNC_DRAW32, 64'h5555555555555555, 1'b0},
		'{FUNC_UNUSED,            64'h0000000000000000, 1'b1},
		'{wella_pkg::FUNC_DRAW64, 64'h0000000000000000, 1'b0},
		'{wella_pkg::FUNC_RESEED, 64'h0123456789abcdef, 1'b1},
		'{wella_pkg::FUNC_RESEED, 64'hfedcba9876543210, 1'b1},
		'{wella_pkg::FUNC_DRAW32, 64'h0000000000000000, 1'b0},
		'{wella_pkg::FUNC_DRAW64, 64'h0000000000000000, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	wella_cmd_if cmd_bus ();
	wella_rnd_if rnd_bus ();

	well1024a_random_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rnd    (rnd_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// generator mirror
	logic [31:0] pool_m [wella_pkg::POOL_WORDS];
	logic [4:0]  pos_m;
	logic [63:0] pending_values [$];

	int error_count = 0;
	bit no_idle     = 1'b0;
	bit rx_hold_req = 1'b0;

	function automatic void load_defaults();
		for (int i = 0; i < wella_pkg::POOL_WORDS; i++)
			pool_m[i] = wella_pkg::DEFAULT_WORDS[i];
		pos_m = 5'd0;
	endfunction

	function automatic logic [31:0] advance_pool();
		logic [4:0]  p, i3, i24, i10, ip;
		logic [31:0] v0, m1, m2, m3, a, b, c;
		p   = pos_m;
		i3  = p + 5'd3;
		i24 = p + 5'd24;
		i10 = p + 5'd10;
		ip  = p - 5'd1;
		v0  = pool_m[p];
		m1  = pool_m[i3];
		m2  = pool_m[i24];
		m3  = pool_m[i10];
		a   = pool_m[ip];
		b   = v0 ^ m1 ^ (m1 >> 8);
		c   = m2 ^ (m2 << 19) ^ m3 ^ (m3 << 14);
		pool_m[p]  = b ^ c;
		pool_m[ip] = a ^ (a << 11) ^ b ^ (b << 7) ^ c ^ (c << 13);
		pos_m = ip;
		return pool_m[ip];
	endfunction

	// updates the mirror for one accepted request, returns number of results queued
	function automatic int apply_request(input logic [1:0] f, input logic [63:0] s);
		logic [31:0] hi, lo;
		int produced;
		produced = 0;
		case (f)
			wella_pkg::FUNC_DRAW32: begin
				lo = advance_pool();
				pending_values.push_back({32'h0, lo});
				produced = 1;
			end
			wella_pkg::FUNC_DRAW64: begin
				hi = advance_pool();
				lo = advance_pool();
				pending_values.push_back({hi, lo});
				produced = 1;
			end
			wella_pkg::FUNC_RESEED: begin
				load_defaults();
				pool_m[0] = s[31:0];
				pool_m[1] = s[63:32];
				for (int k = 0; k < wella_pkg::MIX_STEPS; k++)
					void'(advance_pool());
			end
			default: ;
		endcase
		return produced;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [63:0] pick_seed();
		case ($urandom_range(0, 19))
			0:       return 64'h0;
			1:       return '1;
			2:       return 64'hffffffff00000000;
			3:       return 64'h00000000ffffffff;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [1:0] pick_func();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 46)
			return wella_pkg::FUNC_DRAW32;
		else if (r < 92)
			return wella_pkg::FUNC_DRAW64;
		else if (r < 95)
			return wella_pkg::FUNC_RESEED;
		return FUNC_UNUSED;
	endfunction

	task automatic send_request(input logic [1:0] f, input logic [63:0] s, input int unsigned gap);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.func  <= f;
		cmd_bus.seed  <= s;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
	endtask

	task automatic pause_until_drained();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_values.size() != 0);
	endtask

	// result side
	initial begin : receiver
		int unsigned run_left, gap_left;
		run_left = 0;
		gap_left = 0;
		rnd_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rnd_bus.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				if (no_idle) begin
					rnd_bus.ready <= 1'b1;
				end else if (gap_left > 0) begin
					rnd_bus.ready <= 1'b0;
					gap_left--;
				end else if (run_left > 0) begin
					rnd_bus.ready <= 1'b1;
					run_left--;
				end else begin
					run_left = $urandom_range(1, 24);
					gap_left = pick_gap();
					rnd_bus.ready <= 1'b1;
				end
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		logic [63:0] want;
		if (arst_n && rnd_bus.valid && rnd_bus.ready) begin
			if (pending_values.size() == 0) begin
				$error("value: expected none, got %h", rnd_bus.value);
				error_count++;
			end else begin
				want = pending_values.pop_front();
				if (rnd_bus.value !== want) begin
					$error("value: expected %h, got %h", want, rnd_bus.value);
					error_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (rnd_bus.valid && rnd_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_well1024a_random_generator failed");
		$finish;
	end

	initial begin : stimulus
		logic [1:0]  f;
		logic [63:0] s;
		int          counted, seg, last_seg;
		int unsigned gap;
		counted  = 0;
		last_seg = 0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.func  <= wella_pkg::FUNC_DRAW32;
		cmd_bus.seed  <= '0;
		arst_n = 1'b0;
		load_defaults();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_request(DIRECTED[i].func, DIRECTED[i].seed, pick_gap());
			if ((apply_request(DIRECTED[i].func, DIRECTED[i].seed) == 0) != DIRECTED[i].quiet) begin
				$error("row %0d: result count differs from table", i);
				error_count++;
			end
		end
		pause_until_drained();

		while (counted < RANDOM_ITEMS) begin
			seg = counted / SEGMENT_ITEMS;
			if (seg != last_seg) begin
				last_seg = seg;
				if (seg % 6 == 5)
					pause_until_drained();
				no_idle = (seg % 4 == 3);
				// back the result side up so the input stalls
				if (seg == 2)
					rx_hold_req = 1'b1;
			end
			f   = pick_func();
			s   = pick_seed();
			gap = (no_idle || rx_hold_req) ? 0 : pick_gap();
			send_request(f, s, gap);
			void'(apply_request(f, s));
			if (f != FUNC_UNUSED)
				counted++;
		end
		no_idle = 1'b0;

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_well1024a_random_generator passed");
		else
			$display("tb_well1024a_random_generator failed");
		$finish;
	end

endmodule
